[hw/rtl/imgds_pkg.sv]
// ----------------------------------------------------------------------------
// imgds_pkg
// Shared types, constants and helpers of the two-thirds image downscaler.
// ----------------------------------------------------------------------------
package imgds_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int PIXEL_BITS_DEF = 8;

    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 1;
    localparam int DIM_MIN      = 3;
    localparam int WIDTH_RST    = 640;
    localparam int HEIGHT_RST   = 480;

    // Wide enough for any size, doubled size or output position.
    localparam int POS_BITS = 14;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // Position of a column or row inside its 3x3 source block.
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // Control of the beat held between the line-store read and the result.
    typedef struct packed {
        logic   valid;
        logic   emit;
        t_phase row_phase;
        t_phase col_phase;
        logic   last_in_row;
        logic   last_of_frame;
    } t_s1;

    function automatic t_phase phase_next(input t_phase ph);
        t_phase nxt;
        unique case (ph)
            PH_0:    nxt = PH_1;
            PH_1:    nxt = PH_2;
            default: nxt = PH_0;
        endcase
        return nxt;
    endfunction

    // Quotient by three for values below 8192, by reciprocal multiplication.
    // The error term stays below one ninth of a step, so the floor is exact.
    function automatic logic [CFG_BITS-1:0] div3(input logic [CFG_BITS:0] n);
        logic [27:0] prod;
        prod = 28'(n) * 28'd10923;
        return prod[26:15];
    endfunction

endpackage

[hw/rtl/imgds_pix_if.sv]
// ----------------------------------------------------------------------------
// imgds_pix_if
// Source pixel channel: valid/ready handshake with one gray pixel per beat.
// ----------------------------------------------------------------------------
interface imgds_pix_if #(
    parameter int PIXEL_BITS = imgds_pkg::PIXEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

[hw/rtl/imgds_res_if.sv]
// ----------------------------------------------------------------------------
// imgds_res_if
// Result channel: valid/ready handshake with one output pixel per beat.
// ----------------------------------------------------------------------------
interface imgds_res_if #(
    parameter int VALUE_BITS = imgds_pkg::PIXEL_BITS_DEF + 2
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last_in_row;
    logic                  last_of_frame;

    modport source (output valid, output value, output last_in_row,
                    output last_of_frame, input ready);
    modport sink   (input valid, input value, input last_in_row,
                    input last_of_frame, output ready);
endinterface

[hw/rtl/imgds_ram.sv]
// ----------------------------------------------------------------------------
// imgds_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module imgds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/imgds_ctrl.sv]
// ----------------------------------------------------------------------------
// imgds_ctrl
// Configuration registers, raster position counters and line-store access.
// Each accepted pixel issues one line-store read (and a write in the first
// row of a block row) and moves into the held stage with its control.
// ----------------------------------------------------------------------------
module imgds_ctrl #(
    parameter int MAX_WIDTH  = imgds_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = imgds_pkg::PIXEL_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [imgds_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [imgds_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    input  logic [PIXEL_BITS-1:0]              i_in_pixel,
    output logic                               o_in_ready,
    input  logic                               i_retire,
    output imgds_pkg::t_s1                     o_s1,
    output logic [PIXEL_BITS-1:0]              o_px,
    output logic [PIXEL_BITS-1:0]              o_prev,
    output logic                               o_mem_we,
    output logic                               o_mem_re,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_mem_addr
);
    import imgds_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CFG_BITS-1:0]   r_cfg_w;
    logic [CFG_BITS-1:0]   r_cfg_h;
    logic [CW-1:0]         r_col,  n_col;
    logic [CW-1:0]         r_bcol, n_bcol;
    logic [CFG_BITS-1:0]   r_row,  n_row;
    logic [CFG_BITS-1:0]   r_brow, n_brow;
    t_phase                r_cp,   n_cp;
    t_phase                r_rp,   n_rp;
    logic [PIXEL_BITS-1:0] r_last_px;
    t_s1                   r_s1,   n_s1;
    logic [PIXEL_BITS-1:0] r_px;
    logic [PIXEL_BITS-1:0] r_prev;

    logic [CFG_BITS-1:0] eff_w;
    logic [CFG_BITS-1:0] eff_h;
    logic [CFG_BITS-1:0] out_w;
    logic [CFG_BITS-1:0] out_h;
    logic [POS_BITS-1:0] ocol;
    logic [POS_BITS-1:0] orow;
    logic                accept;
    logic                row_end;
    logic                frame_end;
    logic                lr;

    // Sizes out of range are clamped, as the counters and flags expect.
    always_comb begin
        if (r_cfg_w < CFG_BITS'(DIM_MIN)) begin
            eff_w = CFG_BITS'(DIM_MIN);
        end else if (POS_BITS'(r_cfg_w) > POS_BITS'(MAX_WIDTH)) begin
            eff_w = CFG_BITS'(MAX_WIDTH);
        end else begin
            eff_w = r_cfg_w;
        end
        if (r_cfg_h < CFG_BITS'(DIM_MIN)) begin
            eff_h = CFG_BITS'(DIM_MIN);
        end else begin
            eff_h = r_cfg_h;
        end
    end

    assign out_w = div3({eff_w, 1'b0});
    assign out_h = div3({eff_h, 1'b0});

    assign o_in_ready = !r_s1.valid || i_retire;
    assign accept     = i_in_valid && o_in_ready;

    assign row_end   = (POS_BITS'(r_col) + POS_BITS'(1)) >= POS_BITS'(eff_w);
    assign frame_end = (POS_BITS'(r_row) + POS_BITS'(1)) >= POS_BITS'(eff_h);

    // Output position of this pixel, meaningful only when it emits.
    assign ocol = POS_BITS'({r_bcol, 1'b0}) + POS_BITS'(r_cp == PH_2);
    assign orow = POS_BITS'({r_brow, 1'b0}) + POS_BITS'(r_rp == PH_2);
    assign lr   = (ocol + POS_BITS'(1)) == POS_BITS'(out_w);

    always_comb begin
        n_col  = r_col;
        n_bcol = r_bcol;
        n_cp   = r_cp;
        n_row  = r_row;
        n_brow = r_brow;
        n_rp   = r_rp;
        if (accept) begin
            if (row_end) begin
                n_col  = '0;
                n_bcol = '0;
                n_cp   = PH_0;
                if (frame_end) begin
                    n_row  = '0;
                    n_brow = '0;
                    n_rp   = PH_0;
                end else begin
                    n_row = r_row + CFG_BITS'(1);
                    n_rp  = phase_next(r_rp);
                    if (r_rp == PH_2) begin
                        n_brow = r_brow + CFG_BITS'(1);
                    end
                end
            end else begin
                n_col = r_col + CW'(1);
                n_cp  = phase_next(r_cp);
                if (r_cp == PH_2) begin
                    n_bcol = r_bcol + CW'(1);
                end
            end
        end
    end

    always_comb begin
        n_s1 = r_s1;
        if (accept) begin
            n_s1.valid         = 1'b1;
            n_s1.emit          = (r_rp != PH_0) && (r_cp != PH_0);
            n_s1.row_phase     = r_rp;
            n_s1.col_phase     = r_cp;
            n_s1.last_in_row   = lr;
            n_s1.last_of_frame = lr && ((orow + POS_BITS'(1)) == POS_BITS'(out_h));
        end else if (i_retire) begin
            n_s1.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_BITS'(WIDTH_RST);
            r_cfg_h <= CFG_BITS'(HEIGHT_RST);
            r_col   <= '0;
            r_bcol  <= '0;
            r_cp    <= PH_0;
            r_row   <= '0;
            r_brow  <= '0;
            r_rp    <= PH_0;
            r_s1    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                    default:          ;
                endcase
            end
            r_col  <= n_col;
            r_bcol <= n_bcol;
            r_cp   <= n_cp;
            r_row  <= n_row;
            r_brow <= n_brow;
            r_rp   <= n_rp;
            r_s1   <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px      <= i_in_pixel;
            r_prev    <= r_last_px;
            r_last_px <= i_in_pixel;
        end
    end

    assign o_s1       = r_s1;
    assign o_px       = r_px;
    assign o_prev     = r_prev;
    assign o_mem_we   = accept && (r_rp == PH_0);
    assign o_mem_re   = accept;
    assign o_mem_addr = r_col;

endmodule

[hw/rtl/imgds_calc.sv]
// ----------------------------------------------------------------------------
// imgds_calc
// Block arithmetic on the held beat and the line-store word, the running
// pair sum of a top-left block, and the output register.
// ----------------------------------------------------------------------------
module imgds_calc #(
    parameter int PIXEL_BITS = imgds_pkg::PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  imgds_pkg::t_s1        i_s1,
    input  logic [PIXEL_BITS-1:0] i_px,
    input  logic [PIXEL_BITS-1:0] i_prev,
    input  logic [PIXEL_BITS-1:0] i_stored,
    output logic                  o_retire,
    imgds_res_if.source           o_res
);
    import imgds_pkg::*;

    localparam int VW = PIXEL_BITS + 2;

    logic                  r_valid;
    logic [VW-1:0]         r_value;
    logic                  r_lr;
    logic                  r_lf;
    logic [PIXEL_BITS:0]   r_pair;

    logic                  out_free;
    logic [VW-1:0]         val;
    logic [VW-1:0]         sum_st;
    logic [VW-1:0]         sum_prev;

    assign out_free = !r_valid || o_res.ready;
    // A beat that produces nothing retires without waiting on the output.
    assign o_retire = i_s1.valid && (!i_s1.emit || out_free);

    assign sum_st   = VW'(i_stored) + VW'(i_px);
    assign sum_prev = VW'(i_prev) + VW'(i_px);

    always_comb begin
        unique case ({i_s1.row_phase, i_s1.col_phase})
            {PH_1, PH_1}: val = VW'(r_pair) + sum_st;
            {PH_1, PH_2}: val = {sum_st[VW-2:0], 1'b0};
            {PH_2, PH_1}: val = {sum_prev[VW-2:0], 1'b0};
            {PH_2, PH_2}: val = {i_px, 2'b00};
            default:      val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_retire && i_s1.emit) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_retire && i_s1.emit) begin
            r_value <= val;
            r_lr    <= i_s1.last_in_row;
            r_lf    <= i_s1.last_of_frame;
        end
        if (o_retire && (i_s1.row_phase == PH_1) && (i_s1.col_phase == PH_0)) begin
            r_pair <= (PIXEL_BITS+1)'(i_stored) + (PIXEL_BITS+1)'(i_px);
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.value         = r_value;
    assign o_res.last_in_row   = r_lr;
    assign o_res.last_of_frame = r_lf;

endmodule

[hw/rtl/image_downsample_three_to_two.sv]
// ----------------------------------------------------------------------------
// image_downsample_three_to_two
// Scales a raster gray image by two thirds in each axis, 3x3 blocks to 2x2.
// ----------------------------------------------------------------------------
// Pixels enter on i_pix in raster order, one per beat. Results leave on o_res
// in raster order as unsigned values with two fraction bits, flagged on the
// last result of each output row and of the frame. Source rows and columns
// beyond the last full output are consumed and produce nothing.
// image_width and image_height are written through the plain write port
// (index 0 and 1) while no pixel is in flight; they reset to 640 x 480.
// The block takes one pixel per cycle while i_pix ready is high: the first
// source row of each block row goes into a line store of MAX_WIDTH words,
// and every later pixel costs one read of that store, so the store's single
// read and write per cycle set the rate. A held stage and an output register
// part the two sides; when the receiver stalls, pixels that complete no result
// keep flowing, and i_pix ready drops once a pixel that completes one waits
// in the held stage behind the full result register. Reset returns the
// position counters to the frame start; the line store is not cleared.
// ----------------------------------------------------------------------------
module image_downsample_three_to_two #(
    parameter int MAX_WIDTH  = imgds_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = imgds_pkg::PIXEL_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [imgds_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [imgds_pkg::CFG_BITS-1:0]     i_cfg_data,
    imgds_pix_if.sink                          i_pix,
    imgds_res_if.source                        o_res
);
    import imgds_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    t_s1                   w_s1;
    logic                  w_retire;
    logic                  w_in_ready;
    logic [PIXEL_BITS-1:0] w_px;
    logic [PIXEL_BITS-1:0] w_prev;
    logic [PIXEL_BITS-1:0] w_stored;
    logic                  w_mem_we;
    logic                  w_mem_re;
    logic [CW-1:0]         w_mem_addr;

    assign i_pix.ready = w_in_ready;

    imgds_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_pix.valid),
        .i_in_pixel  (i_pix.pixel),
        .o_in_ready  (w_in_ready),
        .i_retire    (w_retire),
        .o_s1        (w_s1),
        .o_px        (w_px),
        .o_prev      (w_prev),
        .o_mem_we    (w_mem_we),
        .o_mem_re    (w_mem_re),
        .o_mem_addr  (w_mem_addr)
    );

    imgds_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_addr),
        .i_wdata (i_pix.pixel),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_addr),
        .o_rdata (w_stored)
    );

    imgds_calc #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s1     (w_s1),
        .i_px     (w_px),
        .i_prev   (w_prev),
        .i_stored (w_stored),
        .o_retire (w_retire),
        .o_res    (o_res)
    );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-thirds image downscaler.
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order while an in-bench predictor follows the
// same block walk as the design and queues the expected output pixels. Each
// result beat is compared field by field with the oldest queued expectation.
// Directed tests cover the smallest frame, a width register beyond the line
// store, a tall height setting, size writes in the middle of a frame and a
// long output hold-off. Random traffic then runs under several sender gap
// and receiver stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import imgds_pkg::*;

    localparam int DRAIN_CYCLES   = 6;
    localparam int TAIL_CYCLES    = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 40;
    localparam int PHASE_PIXELS   = 40;
    localparam int WIDE_PIXELS    = 24;

    typedef struct packed {
        logic [PIXEL_BITS_DEF+1:0] value;
        logic                      last_in_row;
        logic                      last_of_frame;
    } t_out_pixel;

    // One 3x3 block whose values toggle every pixel bit both ways.
    localparam logic [7:0] MIXED_BLOCK [9] = '{
        8'd0, 8'd255, 8'd170, 8'd85, 8'd1, 8'd128, 8'd254, 8'd127, 8'd64
    };

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    imgds_pix_if pix_if ();
    imgds_res_if res_if ();

    image_downsample_three_to_two u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_if),
        .o_res       (res_if)
    );

    // Traffic shaping.
    int   gap_pct;
    int   stall_pct;
    logic hold_active;
    event backpressure_go;

    // Predictor state: size registers, line store and block walk position.
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    logic [7:0]          line_store [MAX_WIDTH_DEF];
    logic [8:0]          pair_sum;
    logic [7:0]          prev_pix;
    int unsigned         col_idx;
    int unsigned         row_idx;
    t_phase              col_ph;
    t_phase              row_ph;

    t_out_pixel expected_pixels [$];
    t_out_pixel want_pixel;

    int pixels_sent;
    int results_checked;
    int frames_seen;
    int mismatch_count;
    int quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamped_width();
        if (width_reg < DIM_MIN) return DIM_MIN;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return width_reg;
    endfunction

    function automatic logic [7:0] random_pixel();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Advances the block walk by one source pixel and queues the output pixel
    // that it completes, if any.
    function automatic void predict_pixel(input logic [7:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned sum;
        int unsigned ocol;
        int unsigned orow;
        logic [7:0]  stored;
        logic        emit;
        t_out_pixel  res;

        w = clamped_width();
        h = (height_reg < DIM_MIN) ? DIM_MIN : height_reg;
        stored = line_store[col_idx];
        emit = 1'b0;
        sum = 0;

        case (row_ph)
            PH_0: line_store[col_idx] = px;
            PH_1: begin
                case (col_ph)
                    PH_0: pair_sum = stored + px;
                    PH_1: begin
                        sum = pair_sum + stored + px;
                        emit = 1'b1;
                    end
                    default: begin
                        sum = 2 * (stored + px);
                        emit = 1'b1;
                    end
                endcase
            end
            default: begin
                if (col_ph == PH_1) begin
                    sum = 2 * (prev_pix + px);
                    emit = 1'b1;
                end else if (col_ph == PH_2) begin
                    sum = 4 * px;
                    emit = 1'b1;
                end
            end
        endcase

        if (emit) begin
            ocol = 2 * (col_idx / 3) + int'(col_ph) - 1;
            orow = 2 * (row_idx / 3) + int'(row_ph) - 1;
            res.value = 10'(sum);
            res.last_in_row = (ocol + 1 == (2 * w) / 3);
            res.last_of_frame = res.last_in_row && (orow + 1 == (2 * h) / 3);
            expected_pixels.push_back(res);
        end

        prev_pix = px;
        if (col_idx + 1 >= w) begin
            col_idx = 0;
            col_ph = PH_0;
            if (row_idx + 1 >= h) begin
                row_idx = 0;
                row_ph = PH_0;
            end else begin
                row_idx = (row_idx + 1) & 32'hFFF;
                row_ph = (row_ph == PH_2) ? PH_0 : t_phase'(row_ph + 1);
            end
        end else begin
            col_idx = col_idx + 1;
            col_ph = (col_ph == PH_2) ? PH_0 : t_phase'(col_ph + 1);
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] result %0d: %s", $time, results_checked, what);
        end
    endtask

    // Entered and left at a falling edge. Valid stays high on return so that
    // back-to-back beats never lower and raise it in one step.
    task automatic push_pixel(input logic [7:0] px);
        while ($urandom_range(99) < gap_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        do @(posedge clk); while (!pix_if.ready);
        predict_pixel(px);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Sends random pixels until the walk is back at the frame start.
    task automatic frame_tail();
        do push_pixel(random_pixel()); while (col_idx != 0 || row_idx != 0);
    endtask

    // Waits until every queued result has left and the pipeline is empty.
    task automatic drain();
        pix_if.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) begin
            width_reg = val;
        end else begin
            height_reg = val;
        end
    endtask

    task automatic configure(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
        drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // Sizes below three are raised to three, so this is a 3x3 frame. One
    // block at full scale, then one with mixed values.
    task automatic test_smallest_frames();
        gap_pct = 0;
        stall_pct = 0;
        configure(12'd0, 12'd2);
        repeat (9) push_pixel(8'hFF);
        foreach (MIXED_BLOCK[i]) push_pixel(MIXED_BLOCK[i]);
    endtask

    // Height lowered below the current row, width lowered inside a row, and
    // height raised, each in the middle of a frame.
    task automatic test_mid_frame_resize();
        configure(12'd3, 12'd4095);
        repeat (36) push_pixel(random_pixel());
        drain();
        write_reg(REG_IMAGE_HEIGHT, 12'd4);
        frame_tail();

        configure(12'd9, 12'd6);
        repeat (13) push_pixel(random_pixel());
        drain();
        write_reg(REG_IMAGE_WIDTH, 12'd6);
        frame_tail();

        configure(12'd6, 12'd3);
        repeat (8) push_pixel(random_pixel());
        drain();
        write_reg(REG_IMAGE_HEIGHT, 12'd7);
        frame_tail();
    endtask

    // Width register beyond the line store is used as the store size. Part
    // of such a row is sent, then the width is lowered so that the row ends.
    task automatic test_widest_row();
        configure(12'd4095, 12'd2);
        repeat (WIDE_PIXELS) push_pixel(random_pixel());
        drain();
        write_reg(REG_IMAGE_WIDTH, 12'd6);
        frame_tail();
    endtask

    // The receiver holds off while the sender keeps offering pixels.
    task automatic test_output_backpressure();
        configure(12'd12, 12'd9);
        -> backpressure_go;
        repeat (60) push_pixel(random_pixel());
        frame_tail();
    endtask

    task automatic test_random_traffic(input int gap, input int stall, input int count);
        int target;
        logic [CFG_BITS-1:0] next_w;
        logic [CFG_BITS-1:0] next_h;

        gap_pct = gap;
        stall_pct = stall;
        target = pixels_sent + count;
        while (pixels_sent < target) begin
            if (col_idx == 0 && row_idx == 0 && $urandom_range(1) == 0) begin
                next_w = ($urandom_range(15) == 0) ? 12'($urandom_range(2))
                                                   : 12'($urandom_range(3, 20));
                next_h = ($urandom_range(15) == 0) ? 12'($urandom_range(2))
                                                   : 12'($urandom_range(3, 10));
                configure(next_w, next_h);
            end else if ($urandom_range(149) == 0) begin
                // A width may only shrink here, or later rows would read line
                // store words that this block row never wrote.
                drain();
                if ($urandom_range(1) == 0) begin
                    write_reg(REG_IMAGE_HEIGHT, 12'($urandom_range(3, 10)));
                end else begin
                    write_reg(REG_IMAGE_WIDTH, 12'($urandom_range(DIM_MIN, clamped_width())));
                end
            end
            push_pixel(random_pixel());
        end
        if (col_idx != 0 || row_idx != 0) frame_tail();
    endtask

    initial begin
        hold_active = 1'b0;
        forever begin
            @(backpressure_go);
            @(posedge clk);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_if.ready <= !hold_active && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("beat with nothing expected, value %0d",
                                          res_if.value));
            end else begin
                want_pixel = expected_pixels.pop_front();
                if (res_if.value !== want_pixel.value) begin
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              res_if.value, want_pixel.value));
                end
                if (res_if.last_in_row !== want_pixel.last_in_row) begin
                    report_mismatch($sformatf("last_in_row %0b, expected %0b",
                                              res_if.last_in_row, want_pixel.last_in_row));
                end
                if (res_if.last_of_frame !== want_pixel.last_of_frame) begin
                    report_mismatch($sformatf("last_of_frame %0b, expected %0b",
                                              res_if.last_of_frame,
                                              want_pixel.last_of_frame));
                end
                if (want_pixel.last_of_frame) frames_seen++;
            end
            results_checked++;
        end
    end

    always @(posedge clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("No beat for %0d cycles, %0d results still expected.",
                     quiet_cycles, expected_pixels.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        pix_if.valid    = 1'b0;
        pix_if.pixel    = '0;
        cfg_we          = 1'b0;
        cfg_index       = REG_IMAGE_WIDTH;
        cfg_data        = '0;
        gap_pct         = 0;
        stall_pct       = 0;
        pixels_sent     = 0;
        results_checked = 0;
        frames_seen     = 0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        width_reg       = WIDTH_RST;
        height_reg      = HEIGHT_RST;
        pair_sum        = '0;
        prev_pix        = '0;
        col_idx         = 0;
        row_idx         = 0;
        col_ph          = PH_0;
        row_ph          = PH_0;
        rst_n           = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_smallest_frames();
        test_mid_frame_resize();
        test_widest_row();
        test_output_backpressure();
        test_random_traffic(0, 0, PHASE_PIXELS);
        test_random_traffic(69, 0, PHASE_PIXELS);
        test_random_traffic(0, 69, PHASE_PIXELS);
        test_random_traffic(16, 16, PHASE_PIXELS);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d source pixels and checked %0d output pixels in %0d frames,",
                 pixels_sent, results_checked, frames_seen);
        $display("from clamped 3x3 frames to an oversized width and a 4095-row height.");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches found.", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/imgds_pkg.sv
hw/rtl/imgds_pix_if.sv
hw/rtl/imgds_res_if.sv
hw/rtl/imgds_ram.sv
hw/rtl/imgds_ctrl.sv
hw/rtl/imgds_calc.sv
hw/rtl/image_downsample_three_to_two.sv
tb/testbench.sv
